[rtl/smq_pkg.sv]
// ----------------------------------------------------------------------------
// smq_pkg
// Shared constants, operation codes and memory request types of the stack
// with median query.
// ----------------------------------------------------------------------------
package smq_pkg;

	localparam int STACK_DEPTH = 65536;
	localparam int VALUE_LIMIT = 131072;

	localparam int VAL_W    = 17;
	localparam int OP_W     = 2;
	localparam int ADDR_W   = $clog2(STACK_DEPTH);
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int TREE_AW  = $clog2(VALUE_LIMIT);
	localparam int IDX_W    = TREE_AW + 1;
	localparam int TDATA_W  = ((VAL_W + 7) / 8) * 8;
	localparam int TOP_STEP = 1 << (TREE_AW - 1);

	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

	typedef struct packed {
		logic               wr_en;
		logic [TREE_AW-1:0] wr_addr;
		logic [CNT_W-1:0]   wr_data;
		logic [TREE_AW-1:0] rd_addr;
	} tree_req_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [VAL_W-1:0]  wr_data;
		logic [ADDR_W-1:0] rd_addr;
	} stk_req_t;

endpackage

[rtl/stack_with_median_query_unit.sv]
// ----------------------------------------------------------------------------
// stack_with_median_query_unit
// Bounded stack of positive values that answers lower-median queries.
// ----------------------------------------------------------------------------
// The slave channel takes one command word: tuser holds the operation (push,
// pop, peek median) and tdata the value to push. The master channel returns
// one result word for every pop, every peek and every rejected push; an
// accepted push and the unused operation code return nothing. tuser flags an
// invalid request, in which case tdata is zero.
// An update walks the count tree from the value's index up, one to seventeen
// levels depending on the value, and a median descent always walks all
// seventeen. Each level is a registered read, then a write or a compare.
// A result word is presented at the edge at which the block turns ready
// again. The block accepts one word at a time.
// After reset the block clears the count tree, one entry a cycle, and is not
// ready until every entry is cleared.
// A finished result waits in an output register; the next command word is
// taken meanwhile, and only a second result waits until the receiver takes
// the first.
// ----------------------------------------------------------------------------
module stack_with_median_query_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [smq_pkg::TDATA_W-1:0]    s_tdata,   // value
	input  logic [smq_pkg::OP_W-1:0]       s_tuser,   // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [smq_pkg::TDATA_W-1:0]    m_tdata,   // result_value
	output logic                           m_tuser    // invalid
);
	import smq_pkg::*;

	tree_req_t        tree_req;
	stk_req_t         stk_req;
	logic [CNT_W-1:0] tree_rd_data;
	logic [VAL_W-1:0] stk_rd_data;
	logic [VAL_W-1:0] out_value;

	smq_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (s_tuser),
		.in_value     (s_tdata[VAL_W-1:0]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_invalid  (m_tuser),
		.out_value    (out_value),
		.tree_req     (tree_req),
		.tree_rd_data (tree_rd_data),
		.stk_req      (stk_req),
		.stk_rd_data  (stk_rd_data)
	);

	smq_tree u_tree (
		.clk     (clk),
		.req     (tree_req),
		.rd_data (tree_rd_data)
	);

	smq_stack u_stack (
		.clk     (clk),
		.req     (stk_req),
		.rd_data (stk_rd_data)
	);

	assign m_tdata = {{(TDATA_W-VAL_W){1'b0}}, out_value};

endmodule

[rtl/smq_stack.sv]
// ----------------------------------------------------------------------------
// smq_stack
// Value store of the stack: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module smq_stack (
	input  logic                     clk,
	input  smq_pkg::stk_req_t        req,
	output logic [smq_pkg::VAL_W-1:0] rd_data
);
	import smq_pkg::*;

	logic [VAL_W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data <= mem[req.rd_addr];
	end

endmodule

[rtl/smq_tree.sv]
// ----------------------------------------------------------------------------
// smq_tree
// Binary indexed count tree memory: one write and one registered read per
// cycle.
// ----------------------------------------------------------------------------
module smq_tree (
	input  logic                     clk,
	input  smq_pkg::tree_req_t       req,
	output logic [smq_pkg::CNT_W-1:0] rd_data
);
	import smq_pkg::*;

	logic [CNT_W-1:0] mem [VALUE_LIMIT];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data <= mem[req.rd_addr];
	end

endmodule

[rtl/smq_seq.sv]
// ----------------------------------------------------------------------------
// smq_seq
// Sequencer with its add and compare logic: clears the tree, walks it
// for updates and median descents, and holds the result word.
// ----------------------------------------------------------------------------
module smq_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [smq_pkg::OP_W-1:0]    in_op,
	input  logic [smq_pkg::VAL_W-1:0]   in_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        out_invalid,
	output logic [smq_pkg::VAL_W-1:0]   out_value,
	output smq_pkg::tree_req_t          tree_req,
	input  logic [smq_pkg::CNT_W-1:0]   tree_rd_data,
	output smq_pkg::stk_req_t           stk_req,
	input  logic [smq_pkg::VAL_W-1:0]   stk_rd_data
);
	import smq_pkg::*;

	typedef enum logic [8:0] {
		ST_CLEAR    = 9'b000000001,
		ST_IDLE     = 9'b000000010,
		ST_POP_RD   = 9'b000000100,
		ST_POP_GET  = 9'b000001000,
		ST_UPD_RD   = 9'b000010000,
		ST_UPD_WR   = 9'b000100000,
		ST_FIND_RD  = 9'b001000000,
		ST_FIND_CMP = 9'b010000000,
		ST_FIN      = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [TREE_AW-1:0] clr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic               up_q;
	logic [TREE_AW-1:0] pos_q;
	logic [TREE_AW-1:0] step_q;
	logic [CNT_W-1:0]   tgt_q;
	logic [VAL_W-1:0]   res_q;
	logic               inv_q;
	logic               has_res_q;
	logic               out_valid_q;
	logic               out_inv_q;
	logic [VAL_W-1:0]   out_val_q;

	logic               accept;
	logic               push_ok;
	logic [IDX_W-1:0]   idx_next;
	logic [IDX_W-1:0]   nxt;
	logic               take;
	logic [TREE_AW-1:0] pos_next;
	logic [CNT_W:0]     half_sum;
	logic               load_out;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign push_ok   = (cnt_q < CNT_W'(STACK_DEPTH)) && (in_value != '0)
	                   && ({{(IDX_W-VAL_W){1'b0}}, in_value} < IDX_W'(VALUE_LIMIT));
	assign idx_next  = idx_q + (idx_q & (~idx_q + IDX_W'(1)));
	assign nxt       = {1'b0, pos_q} + {1'b0, step_q};
	assign take      = (nxt < IDX_W'(VALUE_LIMIT)) && (tree_rd_data < tgt_q);
	assign pos_next  = take ? nxt[TREE_AW-1:0] : pos_q;
	assign half_sum  = ({1'b0, cnt_q} + (CNT_W+1)'(1)) >> 1;
	assign load_out  = (state_q == ST_FIN) && has_res_q && (!out_valid_q || out_ready);

	always_comb begin
		tree_req         = '0;
		stk_req          = '0;
		stk_req.wr_addr  = cnt_q[ADDR_W-1:0];
		stk_req.wr_data  = in_value;
		stk_req.rd_addr  = cnt_q[ADDR_W-1:0];
		tree_req.rd_addr = idx_q[TREE_AW-1:0];
		tree_req.wr_addr = idx_q[TREE_AW-1:0];
		tree_req.wr_data = up_q ? tree_rd_data + CNT_W'(1) : tree_rd_data - CNT_W'(1);
		unique case (state_q)
			ST_CLEAR: begin
				tree_req.wr_en   = 1'b1;
				tree_req.wr_addr = clr_q;
				tree_req.wr_data = '0;
			end
			ST_IDLE: begin
				stk_req.wr_en = accept && (in_op == OP_PUSH) && push_ok;
			end
			ST_UPD_WR: begin
				tree_req.wr_en = 1'b1;
			end
			ST_FIND_RD, ST_FIND_CMP: begin
				tree_req.rd_addr = nxt[TREE_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			has_res_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + TREE_AW'(1);
					if (clr_q == TREE_AW'(VALUE_LIMIT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_FIN;
						has_res_q <= 1'b1;
						case (in_op)
							OP_PUSH: begin
								if (push_ok) begin
									cnt_q     <= cnt_q + CNT_W'(1);
									has_res_q <= 1'b0;
									state_q   <= ST_UPD_RD;
								end
							end
							OP_POP: begin
								if (cnt_q != '0) begin
									cnt_q   <= cnt_q - CNT_W'(1);
									state_q <= ST_POP_RD;
								end
							end
							OP_PEEK: begin
								if (cnt_q != '0) begin
									state_q <= ST_FIND_RD;
								end
							end
							default: begin
								has_res_q <= 1'b0;
							end
						endcase
					end
				end
				ST_POP_RD: begin
					state_q <= ST_POP_GET;
				end
				ST_POP_GET: begin
					state_q <= ST_UPD_RD;
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_WR;
				end
				ST_UPD_WR: begin
					if ((idx_next == '0) || (idx_next >= IDX_W'(VALUE_LIMIT))) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_UPD_RD;
					end
				end
				ST_FIND_RD: begin
					state_q <= ST_FIND_CMP;
				end
				ST_FIND_CMP: begin
					if (step_q == TREE_AW'(1)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_FIND_RD;
					end
				end
				ST_FIN: begin
					if (!has_res_q || load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				idx_q  <= {{(IDX_W-VAL_W){1'b0}}, in_value};
				up_q   <= (in_op == OP_PUSH);
				inv_q  <= !(((in_op == OP_POP) || (in_op == OP_PEEK)) && (cnt_q != '0));
				res_q  <= '0;
				pos_q  <= '0;
				step_q <= TREE_AW'(TOP_STEP);
				tgt_q  <= half_sum[CNT_W-1:0];
			end
			ST_POP_GET: begin
				idx_q <= {{(IDX_W-VAL_W){1'b0}}, stk_rd_data};
				res_q <= stk_rd_data;
			end
			ST_UPD_WR: begin
				idx_q <= idx_next;
			end
			ST_FIND_CMP: begin
				pos_q  <= pos_next;
				step_q <= step_q >> 1;
				res_q  <= VAL_W'(pos_next + TREE_AW'(1));
				if (take) begin
					tgt_q <= tgt_q - tree_rd_data;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_inv_q <= inv_q;
			out_val_q <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_invalid = out_inv_q;
	assign out_value   = out_val_q;

endmodule

[rtl/smq_checker.sv]
// ----------------------------------------------------------------------------
// smq_checker
// Port-level checks of the stack with median query, bound to the top level.
// ----------------------------------------------------------------------------
module smq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [smq_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tuser
);
	import smq_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// An invalid result carries a zero value.
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("invalid result with nonzero value");

	// A served pop or median is a stored value, never zero or out of range.
	a_val_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[VAL_W-1:0] != '0
		&& (m_tdata >> VAL_W) == '0)
		else $error("served result out of range");

	// The block is busy in the cycle after it takes a command word.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after a command word");

endmodule

bind stack_with_median_query_unit smq_checker u_smq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
